// ===== hw/rtl/bba_pkg.sv =====
// bba_pkg: shared constants, codes and controller/datapath structs for the
// buddy block allocator. No dependencies.
package bba_pkg;

  localparam int MaxOrder  = 10;
  localparam int BlkW      = MaxOrder;
  localparam int LinkW     = MaxOrder + 1;
  localparam int NodeW     = MaxOrder + 1;
  localparam int OrdW      = 4;
  localparam int StW       = 3;
  localparam int CfgW      = 11;
  localparam int NumBlocks = 1 << MaxOrder;
  localparam int NumNodes  = (2 << MaxOrder) - 1;

  localparam logic [LinkW-1:0] Nil = {LinkW{1'b1}};

  localparam logic RegTopOrder    = 1'b0;
  localparam logic RegUsableBlocks = 1'b1;

  typedef enum logic [1:0] {
    NODE_FREE  = 2'd0,
    NODE_PART  = 2'd1,
    NODE_ALLOC = 2'd2
  } node_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_PAST_END  = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_WAIT_IN,
    CMD_SET_J,
    CMD_SPLIT_RD,
    CMD_RM_WR,
    CMD_TA_HALF,
    CMD_TA_GRANT,
    CMD_TA_UP,
    CMD_ADD1_HALF,
    CMD_ADD1_SPLIT,
    CMD_ADD1_FREE,
    CMD_ADD2,
    CMD_ADD2_DEC,
    CMD_FINAL_RD,
    CMD_F_INIT,
    CMD_F_DESC,
    CMD_F_SETFREE,
    CMD_F_BUDRD,
    CMD_F_MERGE,
    CMD_FINISH,
    CMD_OUT_LOAD
  } cmd_e;

  typedef struct packed {
    cmd_e    op;
    status_e code;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic action;
    logic too_large;
    logic found;
    logic split_more;
    logic half_bad;
    logic n_zero;
    logic grant_bad;
    logic free_oob;
    logic st_alloc;
    logic st_part;
    logic o_zero;
    logic start_mismatch;
    logic start_bad;
    logic can_merge;
    logic bud_free;
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/bba_if.sv =====
// bba_req_if and bba_rsp_if: valid/ready channels for requests and results.
// Depends on bba_pkg.
interface bba_req_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [OrdW-1:0]   req_order;
  logic [BlkW-1:0]   free_index;
  modport source (output valid, action, req_order, free_index, input ready);
  modport sink (input valid, action, req_order, free_index, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic [StW-1:0]    status;
  logic [BlkW-1:0]   granted_index;
  modport source (output valid, status, granted_index, input ready);
  modport sink (input valid, status, granted_index, output ready);
endinterface

// ===== hw/rtl/bba_datapath.sv =====
// bba_datapath: free-list heads, link and node-state memories, config and
// operand registers, result register. Executes one command per cycle.
// Depends on bba_pkg and bba_if.
module bba_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [bba_pkg::CfgW-1:0] cfg_wdata_i,
  bba_req_if.sink                req_i,
  bba_rsp_if.source              rsp_o,
  input  bba_pkg::ctl_cmd_t      cmd_i,
  output bba_pkg::dp_status_t    stat_o
);
  import bba_pkg::*;

  logic [OrdW-1:0]  top_q;
  logic [CfgW-1:0]  usable_q;
  logic [LinkW-1:0] heads_q [MaxOrder+1];
  logic [NodeW-1:0] clr_q;

  logic             action_q;
  logic [OrdW-1:0]  req_q;
  logic [BlkW-1:0]  fidx_q;
  logic [OrdW-1:0]  j_q;
  logic [BlkW-1:0]  x_q;
  logic [CfgW-1:0]  y_q;
  logic [OrdW-1:0]  xo_q;
  logic [NodeW-1:0] n_q;
  logic [OrdW-1:0]  o_q;
  logic [BlkW-1:0]  start_q;
  logic [LinkW-1:0] h_q;
  logic [BlkW-1:0]  blk_q;
  logic [LinkW-1:0] nx_q;
  logic [LinkW-1:0] pv_q;
  node_e            nd_q;

  status_e          res_status_q;
  logic [BlkW-1:0]  res_granted_q;
  logic             out_valid_q;
  logic [StW-1:0]   out_status_q;
  logic [BlkW-1:0]  out_granted_q;

  logic [LinkW-1:0] next_mem [NumBlocks];
  logic [LinkW-1:0] prev_mem [NumBlocks];
  node_e            node_mem [NumNodes];

  logic             nm_we, pm_we, tm_we, lk_re, tm_re;
  logic [BlkW-1:0]  nm_wa, pm_wa, lk_ra;
  logic [LinkW-1:0] nm_wd, pm_wd;
  logic [NodeW-1:0] tm_wa, tm_ra;
  node_e            tm_wd;

  logic [OrdW-1:0]  top_new;
  logic [CfgW-1:0]  usable_raw, usable_max, usable_new;
  logic [OrdW-1:0]  first_j;
  logic             found;
  logic [LinkW-1:0] head_j;
  logic [OrdW-1:0]  j_m1, o_m1, o_p1;
  logic [CfgW-1:0]  half_w, grant_end;
  logic [BlkW-1:0]  fidx_sh, bud_blk, start_mrg, add_blk;
  logic [OrdW-1:0]  add_ord;
  logic [NodeW-1:0] n_desc, buddy, n_par, n_ta;
  logic             is_add1, is_rm;

  function automatic logic [NodeW-1:0] node_of(logic [BlkW-1:0] b, logic [OrdW-1:0] o,
                                               logic [OrdW-1:0] t);
    logic [OrdW-1:0] d;
    d = t - o;
    return ((NodeW'(1) << d) - NodeW'(1)) + NodeW'(b >> o);
  endfunction

  // config clamp
  always_comb begin
    top_new    = top_q;
    usable_raw = usable_q;
    if (cfg_idx_i == RegTopOrder) begin
      top_new = (cfg_wdata_i[OrdW-1:0] > OrdW'(MaxOrder)) ? OrdW'(MaxOrder)
                                                           : cfg_wdata_i[OrdW-1:0];
    end else begin
      usable_raw = cfg_wdata_i;
    end
    usable_max = CfgW'(1) << top_new;
    usable_new = usable_raw;
    if (usable_new < CfgW'(1)) usable_new = CfgW'(1);
    if (usable_new > usable_max) usable_new = usable_max;
  end

  // smallest non-empty list at or above the request
  always_comb begin
    first_j = '0;
    found   = 1'b0;
    for (int k = MaxOrder; k >= 0; k--) begin
      if (OrdW'(k) >= req_q && OrdW'(k) <= top_q && heads_q[k] != Nil) begin
        first_j = OrdW'(k);
        found   = 1'b1;
      end
    end
  end

  assign head_j    = heads_q[j_q];
  assign j_m1      = j_q - OrdW'(1);
  assign o_m1      = o_q - OrdW'(1);
  assign o_p1      = o_q + OrdW'(1);
  assign half_w    = {1'b0, head_j[BlkW-1:0]} + (CfgW'(1) << j_m1);
  assign grant_end = {1'b0, x_q} + (CfgW'(1) << req_q) - CfgW'(1);
  assign fidx_sh   = fidx_q >> o_m1;
  assign n_desc    = {n_q[NodeW-2:0], 1'b0} + NodeW'(1) + NodeW'(fidx_sh[0]);
  assign buddy     = n_q[0] ? n_q + NodeW'(1) : n_q - NodeW'(1);
  assign n_par     = (n_q - NodeW'(1)) >> 1;
  assign bud_blk   = start_q ^ (BlkW'(1) << o_q);
  assign start_mrg = start_q & ~((BlkW'(1) << o_p1) - BlkW'(1));
  assign n_ta      = (cmd_i.op == CMD_TA_HALF) ? node_of(y_q[BlkW-1:0], j_m1, top_q)
                                               : node_of(x_q, req_q, top_q);
  assign is_add1   = cmd_i.op == CMD_ADD1_HALF || cmd_i.op == CMD_ADD1_SPLIT ||
                     cmd_i.op == CMD_ADD1_FREE;
  assign is_rm     = cmd_i.op == CMD_RM_WR || cmd_i.op == CMD_F_MERGE;

  always_comb begin
    add_blk = x_q;
    add_ord = j_m1;
    case (cmd_i.op)
      CMD_ADD1_HALF: add_blk = y_q[BlkW-1:0];
      CMD_ADD1_FREE: begin
        add_blk = start_q;
        add_ord = o_q;
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    nm_we = 1'b0; nm_wa = '0; nm_wd = Nil;
    pm_we = 1'b0; pm_wa = '0; pm_wd = Nil;
    tm_we = 1'b0; tm_wa = '0; tm_wd = NODE_FREE;
    lk_re = 1'b0; lk_ra = '0;
    tm_re = 1'b0; tm_ra = '0;
    if (is_rm) begin
      pm_we = nx_q != Nil;
      pm_wa = nx_q[BlkW-1:0];
      pm_wd = pv_q;
      nm_we = pv_q != Nil;
      nm_wa = pv_q[BlkW-1:0];
      nm_wd = nx_q;
    end
    if (is_add1) begin
      nm_we = 1'b1;
      nm_wa = add_blk;
      nm_wd = heads_q[add_ord];
      pm_we = 1'b1;
      pm_wa = add_blk;
      pm_wd = Nil;
    end
    case (cmd_i.op)
      CMD_CLEAR: begin
        tm_we = 1'b1;
        tm_wa = clr_q;
        tm_wd = NODE_FREE;
        nm_we = clr_q == '0;
        pm_we = clr_q == '0;
      end
      CMD_SPLIT_RD: begin
        lk_re = 1'b1;
        lk_ra = head_j[BlkW-1:0];
      end
      CMD_FINAL_RD: begin
        lk_re = 1'b1;
        lk_ra = heads_q[req_q][BlkW-1:0];
      end
      CMD_TA_HALF, CMD_TA_GRANT: begin
        tm_we = 1'b1;
        tm_wa = n_ta;
        tm_wd = NODE_ALLOC;
      end
      CMD_TA_UP: begin
        tm_we = 1'b1;
        tm_wa = n_par;
        tm_wd = NODE_PART;
      end
      CMD_ADD2, CMD_ADD2_DEC: begin
        pm_we = h_q != Nil;
        pm_wa = h_q[BlkW-1:0];
        pm_wd = LinkW'(blk_q);
      end
      CMD_F_INIT: begin
        tm_re = 1'b1;
        tm_ra = '0;
      end
      CMD_F_DESC: begin
        tm_re = 1'b1;
        tm_ra = n_desc;
      end
      CMD_F_SETFREE: begin
        tm_we = 1'b1;
        tm_wa = n_q;
        tm_wd = NODE_FREE;
      end
      CMD_F_BUDRD: begin
        tm_re = 1'b1;
        tm_ra = buddy;
        lk_re = 1'b1;
        lk_ra = bud_blk;
      end
      CMD_F_MERGE: begin
        tm_we = 1'b1;
        tm_wa = n_par;
        tm_wd = NODE_FREE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nm_we) next_mem[nm_wa] <= nm_wd;
    if (pm_we) prev_mem[pm_wa] <= pm_wd;
    if (tm_we) node_mem[tm_wa] <= tm_wd;
    if (lk_re) begin
      nx_q <= next_mem[lk_ra];
      pv_q <= prev_mem[lk_ra];
    end
    if (tm_re) nd_q <= node_mem[tm_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= OrdW'(MaxOrder);
      usable_q    <= CfgW'(NumBlocks);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= MaxOrder; k++) begin
        heads_q[k] <= (k == MaxOrder) ? '0 : Nil;
      end
    end else begin
      if (cmd_i.op == CMD_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == CMD_CLEAR) clr_q <= clr_q + NodeW'(1);
      if (is_rm && pv_q == Nil) heads_q[xo_q] <= nx_q;
      if (is_add1) heads_q[add_ord] <= LinkW'(add_blk);
      if (cfg_we_i) begin
        top_q    <= top_new;
        usable_q <= usable_new;
        clr_q    <= '0;
        for (int k = 0; k <= MaxOrder; k++) begin
          heads_q[k] <= (OrdW'(k) == top_new) ? '0 : Nil;
        end
      end
    end
  end

  // operand and payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      action_q <= req_i.action;
      req_q    <= req_i.req_order;
      fidx_q   <= req_i.free_index;
    end
    if (is_add1) begin
      h_q   <= heads_q[add_ord];
      blk_q <= add_blk;
    end
    case (cmd_i.op)
      CMD_SET_J:    j_q <= first_j;
      CMD_ADD2_DEC: j_q <= j_m1;
      CMD_SPLIT_RD: begin
        x_q  <= head_j[BlkW-1:0];
        y_q  <= half_w;
        xo_q <= j_q;
      end
      CMD_FINAL_RD: begin
        x_q  <= heads_q[req_q][BlkW-1:0];
        xo_q <= req_q;
      end
      CMD_TA_HALF, CMD_TA_GRANT: n_q <= n_ta;
      CMD_TA_UP: n_q <= n_par;
      CMD_F_INIT: begin
        n_q     <= '0;
        o_q     <= top_q;
        start_q <= '0;
      end
      CMD_F_DESC: begin
        n_q     <= n_desc;
        o_q     <= o_m1;
        start_q <= start_q | (BlkW'(fidx_sh[0]) << o_m1);
      end
      CMD_F_BUDRD: xo_q <= o_q;
      CMD_F_MERGE: begin
        n_q     <= n_par;
        o_q     <= o_p1;
        start_q <= start_mrg;
      end
      CMD_FINISH: begin
        res_status_q  <= cmd_i.code;
        res_granted_q <= (cmd_i.code == ST_OK && !action_q) ? x_q : '0;
      end
      CMD_OUT_LOAD: begin
        out_status_q  <= res_status_q;
        out_granted_q <= res_granted_q;
      end
      default: ;
    endcase
  end

  assign req_i.ready         = (cmd_i.op == CMD_WAIT_IN) && !cfg_we_i;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.granted_index = out_granted_q;

  always_comb begin
    stat_o.in_fire        = req_i.valid && req_i.ready;
    stat_o.action         = action_q;
    stat_o.too_large      = req_q > top_q;
    stat_o.found          = found;
    stat_o.split_more     = j_q > req_q;
    stat_o.half_bad       = y_q >= usable_q;
    stat_o.n_zero         = n_q == '0;
    stat_o.grant_bad      = grant_end >= usable_q;
    stat_o.free_oob       = {1'b0, fidx_q} >= (CfgW'(1) << top_q);
    stat_o.st_alloc       = nd_q == NODE_ALLOC;
    stat_o.st_part        = nd_q == NODE_PART;
    stat_o.o_zero         = o_q == '0;
    stat_o.start_mismatch = start_q != fidx_q;
    stat_o.start_bad      = {1'b0, start_q} >= usable_q;
    stat_o.can_merge      = n_q != '0 && o_q < top_q;
    stat_o.bud_free       = nd_q == NODE_FREE;
    stat_o.clr_last       = clr_q == NodeW'(NumNodes - 1);
    stat_o.out_busy       = out_valid_q && !rsp_o.ready;
  end

endmodule

// ===== hw/rtl/bba_controller.sv =====
// bba_controller: sequencer for allocate and free requests and the node
// clearing pass. Drives datapath commands from datapath status. Depends on bba_pkg.
module bba_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  bba_pkg::dp_status_t stat_i,
  output bba_pkg::ctl_cmd_t   cmd_o
);
  import bba_pkg::*;

  typedef enum logic [21:0] {
    S_CLEAR   = 22'h000001,
    S_IDLE    = 22'h000002,
    S_DECODE  = 22'h000004,
    S_A_CHK   = 22'h000008,
    S_A_LOOP  = 22'h000010,
    S_A_RM    = 22'h000020,
    S_A_HALF  = 22'h000040,
    S_A_HTA   = 22'h000080,
    S_A_ADDH2 = 22'h000100,
    S_A_ADDB1 = 22'h000200,
    S_A_ADDB2 = 22'h000400,
    S_A_FIN   = 22'h000800,
    S_A_GRANT = 22'h001000,
    S_A_GTA   = 22'h002000,
    S_F_CHK   = 22'h004000,
    S_F_EV    = 22'h008000,
    S_F_CHK2  = 22'h010000,
    S_F_MRG   = 22'h020000,
    S_F_MEV   = 22'h040000,
    S_F_ADD2  = 22'h080000,
    S_F_END   = 22'h100000,
    S_DONE    = 22'h200000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    cmd_o.code = ST_OK;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = CMD_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.op = CMD_WAIT_IN;
        if (stat_i.in_fire) state_d = S_DECODE;
      end
      S_DECODE: state_d = stat_i.action ? S_F_CHK : S_A_CHK;
      S_A_CHK: begin
        if (stat_i.too_large) begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_TOO_LARGE;
          state_d    = S_DONE;
        end else if (!stat_i.found) begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_NO_FREE;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = CMD_SET_J;
          state_d  = S_A_LOOP;
        end
      end
      S_A_LOOP: begin
        if (stat_i.split_more) begin
          cmd_o.op = CMD_SPLIT_RD;
          state_d  = S_A_RM;
        end else begin
          cmd_o.op = CMD_FINAL_RD;
          state_d  = S_A_FIN;
        end
      end
      S_A_RM: begin
        cmd_o.op = CMD_RM_WR;
        state_d  = S_A_HALF;
      end
      S_A_HALF: begin
        if (stat_i.half_bad) begin
          cmd_o.op = CMD_TA_HALF;
          state_d  = S_A_HTA;
        end else begin
          cmd_o.op = CMD_ADD1_HALF;
          state_d  = S_A_ADDH2;
        end
      end
      S_A_HTA: begin
        if (!stat_i.n_zero) begin
          cmd_o.op = CMD_TA_UP;
        end else begin
          cmd_o.op = CMD_ADD1_SPLIT;
          state_d  = S_A_ADDB2;
        end
      end
      S_A_ADDH2: begin
        cmd_o.op = CMD_ADD2;
        state_d  = S_A_ADDB1;
      end
      S_A_ADDB1: begin
        cmd_o.op = CMD_ADD1_SPLIT;
        state_d  = S_A_ADDB2;
      end
      S_A_ADDB2: begin
        cmd_o.op = CMD_ADD2_DEC;
        state_d  = S_A_LOOP;
      end
      S_A_FIN: begin
        if (stat_i.grant_bad) begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_PAST_END;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = CMD_RM_WR;
          state_d  = S_A_GRANT;
        end
      end
      S_A_GRANT: begin
        cmd_o.op = CMD_TA_GRANT;
        state_d  = S_A_GTA;
      end
      S_A_GTA: begin
        if (!stat_i.n_zero) begin
          cmd_o.op = CMD_TA_UP;
        end else begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_OK;
          state_d    = S_DONE;
        end
      end
      S_F_CHK: begin
        if (stat_i.free_oob) begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_BAD_INDEX;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = CMD_F_INIT;
          state_d  = S_F_EV;
        end
      end
      S_F_EV: begin
        if (stat_i.st_alloc) begin
          state_d = S_F_CHK2;
        end else if (!stat_i.st_part || stat_i.o_zero) begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_BAD_INDEX;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = CMD_F_DESC;
        end
      end
      S_F_CHK2: begin
        if (stat_i.start_mismatch) begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_BAD_INDEX;
          state_d    = S_DONE;
        end else if (stat_i.start_bad) begin
          cmd_o.op   = CMD_FINISH;
          cmd_o.code = ST_PAST_END;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = CMD_F_SETFREE;
          state_d  = S_F_MRG;
        end
      end
      S_F_MRG: begin
        if (stat_i.can_merge) begin
          cmd_o.op = CMD_F_BUDRD;
          state_d  = S_F_MEV;
        end else begin
          cmd_o.op = CMD_ADD1_FREE;
          state_d  = S_F_ADD2;
        end
      end
      S_F_MEV: begin
        if (stat_i.bud_free) begin
          cmd_o.op = CMD_F_MERGE;
          state_d  = S_F_MRG;
        end else begin
          cmd_o.op = CMD_ADD1_FREE;
          state_d  = S_F_ADD2;
        end
      end
      S_F_ADD2: begin
        cmd_o.op = CMD_ADD2;
        state_d  = S_F_END;
      end
      S_F_END: begin
        cmd_o.op   = CMD_FINISH;
        cmd_o.code = ST_OK;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = CMD_OUT_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// buddy_block_allocator_core: top level, controller plus datapath.
// Depends on bba_pkg, bba_if, bba_controller, bba_datapath.
//
//   channel   dir  transfer moves
//   req_i     in   action, req_order, free_index
//   rsp_o     out  status, granted_index
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// one request at a time; allocate takes longer for each split and for each tree level
// above the grant (and above the half when it lies past the usable end); free takes
// longer for each level walked and each merge
// after reset and every config write a clearing pass over all 2047 node states blocks
// requests; a result held by rsp_o.ready stalls the next one in the controller
module buddy_block_allocator_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [bba_pkg::CfgW-1:0] cfg_wdata_i,
  bba_req_if.sink                  req_i,
  bba_rsp_if.source                rsp_o
);
  import bba_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t stat;

  bba_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  bba_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
